### hdl/vario_climb_tone_scheduler_defines.svh
// Assertion macros shared by the scheduler RTL.
// Both expect clk and rst_n in the scope of use.
`ifndef VARIO_CLIMB_TONE_SCHEDULER_DEFINES_SVH
`define VARIO_CLIMB_TONE_SCHEDULER_DEFINES_SVH

// Same-cycle implication
`define VCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define VCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/vct_pkg.sv
package vct_pkg;

  // Moving average length and derived widths
  localparam int AVG_SAMPLES = 5;
  localparam int SLOT_W      = $clog2(AVG_SAMPLES);
  localparam int SAMPLE_W    = 15;
  localparam int SUM_W       = SAMPLE_W + SLOT_W;
  localparam int AVG_W       = 16;
  localparam int QUOT_W      = AVG_W - 1;

  // Exact truncating divide by AVG_SAMPLES: floor(m * R / 2^S)
  localparam int     AVG_SHIFT   = SUM_W + SLOT_W;
  localparam int     AVG_RECIP_W = SUM_W + 2;
  localparam longint AVG_RECIP_L =
    ((longint'(1) << AVG_SHIFT) + longint'(AVG_SAMPLES) - 1) / longint'(AVG_SAMPLES);
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = AVG_RECIP_W'(AVG_RECIP_L);
  localparam int AVG_PROD_W = SUM_W + AVG_RECIP_W;

  // Field widths
  localparam int TIME_W   = 32;
  localparam int HZ_W     = 12;
  localparam int DUTY_W   = 8;
  localparam int VOL_W    = 8;
  localparam int QUIET_W  = 10;
  localparam int PERIOD_W = 16;
  localparam int ONMS_W   = 8;
  localparam int PCT_W    = 7;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 2'd3;

  // Register reset values
  localparam int VOLUME_RST = 200;
  localparam logic signed [SAMPLE_W-1:0] SINK_RST   = -15'sd100;
  localparam logic [QUIET_W-1:0]         QUIET_RST  = 10'd10;
  localparam logic [PERIOD_W-1:0]        PERIOD_RST = 16'd500;

  // Tone constants
  localparam logic [HZ_W-1:0]  ALARM_HZ  = 12'd300;
  localparam logic [HZ_W-1:0]  RESET_HZ  = 12'd1000;
  localparam logic [HZ_W-1:0]  BASE_HZ   = 12'd2000;
  localparam logic signed [AVG_W-1:0] CLIMB_MIN = 16'sd10;
  localparam logic signed [AVG_W-1:0] CLIMB_MAX = 16'sd500;
  localparam logic [ONMS_W-1:0] ON_MIN_MS = 8'd40;
  localparam logic [PCT_W-1:0]  PCT_MIN   = 7'd40;

  // hz step = floor(d * 800 / 490) = floor(d * 80 / 49), folded into one constant
  localparam int HZ_SHIFT = 22;
  localparam logic [22:0] HZ_MUL = 23'(80 * (((1 << HZ_SHIFT) + 48) / 49));

  // on_ms step = floor(v * 180 / 255)
  localparam int ON_SHIFT = 24;
  localparam logic [23:0] ON_MUL = 24'(180 * (((1 << ON_SHIFT) + 254) / 255));

  // pct step = floor(v * 60 / 255)
  localparam int PCT_SHIFT = 22;
  localparam logic [19:0] PCT_MUL = 20'(60 * (((1 << PCT_SHIFT) + 254) / 255));

  // duty = floor(pct * 255 / 100)
  localparam int DUTY_SHIFT = 22;
  localparam logic [23:0] DUTY_MUL = 24'(255 * (((1 << DUTY_SHIFT) + 99) / 100));

  // Derived reset values for volume 200
  localparam logic [ONMS_W-1:0] ON_MS_RST = ONMS_W'(40 + (VOLUME_RST * 180) / 255);
  localparam logic [PCT_W-1:0]  PCT_RST   = PCT_W'(40 + (VOLUME_RST * 60) / 255);
  localparam logic [DUTY_W-1:0] DUTY_RST  =
    DUTY_W'((255 * (40 + (VOLUME_RST * 60) / 255)) / 100);

endpackage

### hdl/vct_if.sv
// Sample channel: climb rate and timestamp
interface vct_in_if
  import vct_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] climb_rate;
  logic [TIME_W-1:0]          time_now;

  modport source (output valid, output climb_rate, output time_now, input ready);
  modport sink   (input valid, input climb_rate, input time_now, output ready);
endinterface

// Result channel: tone state for one sample
interface vct_out_if
  import vct_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              tone_active;
  logic [HZ_W-1:0]   tone_hz;
  logic [DUTY_W-1:0] duty_level;
  logic              retune;

  modport source (output valid, output tone_active, output tone_hz, output duty_level,
                  output retune, input ready);
  modport sink   (input valid, input tone_active, input tone_hz, input duty_level,
                  input retune, output ready);
endinterface

### hdl/vario_climb_tone_scheduler.sv
// Climb tone scheduler: each sample transaction (climb rate in cm/s, time in ms) yields
// exactly one result transaction with the tone state after that sample. The block takes
// one sample per clock cycle unless the output stalls; results are registered. The input
// stage updates the running sum of the last AVG_SAMPLES samples and divides it by a
// reciprocal multiply; the result stage picks alarm, silence or beep and maps the
// average to a tone frequency. Register writes take effect for samples accepted from the
// cycle after the write; a volume change needs that cycle for the duty value.
`include "vario_climb_tone_scheduler_defines.svh"

module vario_climb_tone_scheduler
  import vct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  vct_in_if.sink                in_chan,
  vct_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration and volume-derived values
  logic signed [SAMPLE_W-1:0] sink_r;
  logic [QUIET_W-1:0]         quiet_r;
  logic [PERIOD_W-1:0]        period_r;
  logic [ONMS_W-1:0]          on_ms_r;
  logic [PCT_W-1:0]           pct_r;
  logic [DUTY_W-1:0]          duty_r;
  logic [31:0]                on_prod;
  logic [27:0]                pct_prod;
  logic [30:0]                duty_prod;

  // Scale volume into beep length and duty percent, and the percent into a duty level
  assign on_prod   = 32'(cfg_data[VOL_W-1:0]) * 32'(ON_MUL);
  assign pct_prod  = 28'(cfg_data[VOL_W-1:0]) * 28'(PCT_MUL);
  assign duty_prod = 31'(pct_r) * 31'(DUTY_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sink_r   <= SINK_RST;
      quiet_r  <= QUIET_RST;
      period_r <= PERIOD_RST;
      on_ms_r  <= ON_MS_RST;
      pct_r    <= PCT_RST;
      duty_r   <= DUTY_RST;
    end else begin
      duty_r <= duty_prod[DUTY_SHIFT +: DUTY_W];
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VOLUME: begin
            on_ms_r <= ON_MIN_MS + on_prod[ON_SHIFT +: ONMS_W];
            pct_r   <= PCT_MIN + PCT_W'(pct_prod[PCT_SHIFT +: 6]);
          end
          CFG_SINK_LEVEL: sink_r   <= $signed(cfg_data[SAMPLE_W-1:0]);
          CFG_QUIET:      quiet_r  <= cfg_data[QUIET_W-1:0];
          CFG_PERIOD:     period_r <= cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Handshake between input stage and result register
  logic s1_v_r;
  logic out_v_r;
  logic s2_adv;
  logic in_acc;

  assign s2_adv        = s1_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !s1_v_r || s2_adv;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // Input stage: sample ring, running sum, divide
  logic signed [SAMPLE_W-1:0] store_r [AVG_SAMPLES];
  logic [SLOT_W-1:0]          slot_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic [SUM_W-1:0]           sum_mag;
  logic [AVG_PROD_W-1:0]      avg_prod;
  logic [QUOT_W-1:0]          avg_quot;
  logic signed [AVG_W-1:0]    avg_nxt;
  logic signed [AVG_W-1:0]    avg_r;
  logic [TIME_W-1:0]          now_r;

  always_comb begin
    sum_nxt  = sum_r - SUM_W'(store_r[slot_r]) + SUM_W'(in_chan.climb_rate);
    sum_mag  = sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);
    avg_prod = AVG_PROD_W'(sum_mag) * AVG_PROD_W'(AVG_RECIP);
    avg_quot = avg_prod[AVG_SHIFT +: QUOT_W];
    avg_nxt  = sum_nxt[SUM_W-1] ? -$signed({1'b0, avg_quot}) : $signed({1'b0, avg_quot});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      slot_r <= '0;
      sum_r  <= '0;
      for (int i = 0; i < AVG_SAMPLES; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      if (in_acc) begin
        s1_v_r          <= 1'b1;
        store_r[slot_r] <= in_chan.climb_rate;
        sum_r           <= sum_nxt;
        slot_r          <= (slot_r == SLOT_W'(AVG_SAMPLES - 1)) ? '0 : slot_r + 1'b1;
      end else if (s2_adv) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  // Hold the stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      avg_r <= avg_nxt;
      now_r <= in_chan.time_now;
    end
  end

  // Result stage: tone state
  logic [HZ_W-1:0]         hz_r;
  logic [HZ_W-1:0]         hz_nxt;
  logic                    sounding_r;
  logic                    sounding_nxt;
  logic                    alarm_r;
  logic                    alarm_nxt;
  logic [TIME_W-1:0]       off_time_r;
  logic [TIME_W-1:0]       off_time_nxt;
  logic [TIME_W-1:0]       next_time_r;
  logic [TIME_W-1:0]       next_time_nxt;
  logic                    retune_nxt;
  logic signed [AVG_W-1:0] climb_clamp;
  logic [8:0]              climb_ofs;
  logic [31:0]             hz_prod;
  logic [HZ_W-1:0]         hz_map;

  // Map clamped average climb onto the beep frequency
  always_comb begin
    if (avg_r < CLIMB_MIN) begin
      climb_clamp = CLIMB_MIN;
    end else if (avg_r > CLIMB_MAX) begin
      climb_clamp = CLIMB_MAX;
    end else begin
      climb_clamp = avg_r;
    end
    climb_ofs = 9'(climb_clamp - CLIMB_MIN);
    hz_prod   = 32'(climb_ofs) * 32'(HZ_MUL);
    hz_map    = BASE_HZ + HZ_W'(hz_prod[HZ_SHIFT +: 10]);
  end

  // Pick alarm, silence or beep
  always_comb begin
    hz_nxt        = hz_r;
    sounding_nxt  = sounding_r;
    alarm_nxt     = alarm_r;
    off_time_nxt  = off_time_r;
    next_time_nxt = next_time_r;
    retune_nxt    = 1'b0;
    if (avg_r < AVG_W'(sink_r)) begin
      if (!alarm_r || hz_r != ALARM_HZ) begin
        retune_nxt   = (hz_r != ALARM_HZ);
        hz_nxt       = ALARM_HZ;
        sounding_nxt = 1'b1;
        alarm_nxt    = 1'b1;
      end
    end else begin
      alarm_nxt = 1'b0;
      if (avg_r < $signed({6'd0, quiet_r})) begin
        sounding_nxt = 1'b0;
      end else begin
        if (sounding_r && now_r >= off_time_r) begin
          sounding_nxt = 1'b0;
        end
        if (!sounding_nxt && now_r >= next_time_r) begin
          retune_nxt    = (hz_r != hz_map);
          hz_nxt        = hz_map;
          sounding_nxt  = 1'b1;
          off_time_nxt  = now_r + TIME_W'(on_ms_r);
          next_time_nxt = now_r + TIME_W'(period_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r     <= 1'b0;
      hz_r        <= RESET_HZ;
      sounding_r  <= 1'b0;
      alarm_r     <= 1'b0;
      off_time_r  <= '0;
      next_time_r <= '0;
    end else begin
      if (s2_adv) begin
        out_v_r     <= 1'b1;
        hz_r        <= hz_nxt;
        sounding_r  <= sounding_nxt;
        alarm_r     <= alarm_nxt;
        off_time_r  <= off_time_nxt;
        next_time_r <= next_time_nxt;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Result register payload
  logic              tone_active_r;
  logic [HZ_W-1:0]   tone_hz_r;
  logic [DUTY_W-1:0] duty_level_r;
  logic              retune_r;

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      tone_active_r <= sounding_nxt;
      tone_hz_r     <= hz_nxt;
      duty_level_r  <= sounding_nxt ? duty_r : '0;
      retune_r      <= retune_nxt;
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.tone_active = tone_active_r;
  assign out_chan.tone_hz     = tone_hz_r;
  assign out_chan.duty_level  = duty_level_r;
  assign out_chan.retune      = retune_r;

  // Checks
  `VCT_ASSERT_IMP(a_alarm_tone, alarm_r, sounding_r && hz_r == ALARM_HZ,
                  "alarm without 300 Hz tone")
  `VCT_ASSERT_IMP(a_out_matches_state, out_v_r, out_chan.tone_active == sounding_r,
                  "result disagrees with state")
  `VCT_ASSERT_IMP(a_stall_blocks_input, s1_v_r && out_v_r && !out_chan.ready,
                  !in_chan.ready, "input taken while stalled")
  `VCT_ASSERT_IMP(a_slot_range, 1'b1, slot_r <= SLOT_W'(AVG_SAMPLES - 1),
                  "ring slot out of range")
  `VCT_ASSERT_NXT(a_result_loaded, s2_adv, out_v_r, "advanced sample gave no result")

endmodule

### bench/vct_tone_checker.sv
`timescale 1ns / 1ps

// Watches the sample, result and register ports, keeps its own model of the
// tone scheduler and compares every result transaction with the oldest
// prediction.
module vct_tone_checker
  import vct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  vct_in_if                     in_mon,
  vct_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    outstanding
);

  typedef struct packed {
    logic              tone_active;
    logic [HZ_W-1:0]   tone_hz;
    logic [DUTY_W-1:0] duty_level;
    logic              retune;
  } tone_result_t;

  localparam int REPORT_MAX = 10;

  // Predicted tone state
  int                ring [AVG_SAMPLES];
  int                slot;
  logic [HZ_W-1:0]   cur_hz;
  logic              tone_on;
  logic              alarm_set;
  logic [TIME_W-1:0] off_at;
  logic [TIME_W-1:0] next_at;

  // Shadow registers
  logic [VOL_W-1:0]    vol_reg;
  int                  sink_reg;
  int                  quiet_reg;
  logic [PERIOD_W-1:0] period_reg;

  tone_result_t expected_tones[$];
  tone_result_t want;
  tone_result_t seen;

  // Advance the model by one sample and return the tone state it leaves
  function automatic tone_result_t advance_tone(input logic signed [SAMPLE_W-1:0] rate,
                                                input logic [TIME_W-1:0] now);
    tone_result_t      res;
    int                total;
    int                avg;
    int                clamped;
    int                i;
    logic [TIME_W-1:0] on_ms;
    logic [HZ_W-1:0]   hz;
    logic              changed;

    changed = 1'b0;
    ring[slot] = int'(rate);
    slot = (slot + 1 >= AVG_SAMPLES) ? 0 : slot + 1;
    total = 0;
    for (i = 0; i < AVG_SAMPLES; i++) total += ring[i];
    avg = total / AVG_SAMPLES;

    if (avg < sink_reg) begin
      // steady alarm; leave an alarm that is already sounding alone
      if (!alarm_set || cur_hz != ALARM_HZ) begin
        changed   = (cur_hz != ALARM_HZ);
        cur_hz    = ALARM_HZ;
        tone_on   = 1'b1;
        alarm_set = 1'b1;
      end
    end else begin
      alarm_set = 1'b0;
      if (avg < quiet_reg) begin
        tone_on = 1'b0;
      end else begin
        on_ms = TIME_W'(40 + (int'(vol_reg) * 180) / 255);
        if (tone_on && now >= off_at) tone_on = 1'b0;
        if (!tone_on && now >= next_at) begin
          clamped = avg;
          if (clamped < 10) clamped = 10;
          if (clamped > 500) clamped = 500;
          hz      = HZ_W'(int'(BASE_HZ) + ((clamped - 10) * 800) / 490);
          changed = (hz != cur_hz);
          cur_hz  = hz;
          tone_on = 1'b1;
          off_at  = now + on_ms;
          next_at = now + TIME_W'(period_reg);
        end
      end
    end

    res.tone_active = tone_on;
    res.tone_hz     = cur_hz;
    res.duty_level  = '0;
    if (tone_on) res.duty_level = DUTY_W'((255 * (40 + (int'(vol_reg) * 60) / 255)) / 100);
    res.retune      = changed;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      // Clear model and registers to their reset values
      for (int k = 0; k < AVG_SAMPLES; k++) ring[k] = 0;
      slot           = 0;
      cur_hz         = RESET_HZ;
      tone_on        = 1'b0;
      alarm_set      = 1'b0;
      off_at         = '0;
      next_at        = '0;
      vol_reg        = VOL_W'(VOLUME_RST);
      sink_reg       = int'(SINK_RST);
      quiet_reg      = int'(QUIET_RST);
      period_reg     = PERIOD_RST;
      mismatch_count = 0;
      expected_tones.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_VOLUME:     vol_reg    = cfg_data[VOL_W-1:0];
          CFG_SINK_LEVEL: sink_reg   = int'($signed(cfg_data[SAMPLE_W-1:0]));
          CFG_QUIET:      quiet_reg  = int'(cfg_data[QUIET_W-1:0]);
          CFG_PERIOD:     period_reg = cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end

      // Compare a result transaction with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        seen.tone_active = out_mon.tone_active;
        seen.tone_hz     = out_mon.tone_hz;
        seen.duty_level  = out_mon.duty_level;
        seen.retune      = out_mon.retune;
        if (expected_tones.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("[%0t] unexpected result: active=%0d hz=%0d duty=%0d retune=%0d",
                     $realtime, seen.tone_active, seen.tone_hz, seen.duty_level,
                     seen.retune);
        end else begin
          want = expected_tones.pop_front();
          if (seen.tone_active !== want.tone_active || seen.tone_hz !== want.tone_hz ||
              seen.duty_level !== want.duty_level || seen.retune !== want.retune) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("[%0t] mismatch: want act/hz/duty/rt %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                       $realtime, want.tone_active, want.tone_hz, want.duty_level,
                       want.retune, seen.tone_active, seen.tone_hz, seen.duty_level,
                       seen.retune);
          end
        end
      end

      // Predict the result of an accepted sample transaction
      if (in_mon.valid && in_mon.ready)
        expected_tones.push_back(advance_tone(in_mon.climb_rate, in_mon.time_now));
    end
    outstanding <= expected_tones.size();
  end

endmodule

### bench/tb_vario_climb_tone_scheduler.sv
`timescale 1ns / 1ps

module tb_vario_climb_tone_scheduler;
  import vct_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASE_ITEMS    = 100;
  localparam logic signed [SAMPLE_W-1:0] RATE_MAX = 15'sh3FFF;
  localparam logic signed [SAMPLE_W-1:0] RATE_MIN = 15'sh4000;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatch_count;
  int outstanding;

  int                tx_idle_pct;
  int                rx_idle_pct;
  logic              hold_req;
  logic [TIME_W-1:0] t_ms;
  int                cur_sink;
  int                cur_quiet;

  vct_in_if  in_chan ();
  vct_out_if out_chan ();

  vario_climb_tone_scheduler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vct_tone_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #10 clk = ~clk;

  // Result side: random back-pressure, plus a long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left      = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one sample transaction, with random gaps, and hold it until ready reads high
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] rate,
                             input logic [TIME_W-1:0] stamp);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.climb_rate <= rate;
    in_chan.time_now   <= stamp;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted result has arrived
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers; junk goes into the bits above each width
  task automatic apply_settings(input logic [VOL_W-1:0] vol,
                                input logic signed [SAMPLE_W-1:0] sink,
                                input logic [QUIET_W-1:0] quiet,
                                input logic [PERIOD_W-1:0] period);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_VOLUME;
    cfg_data  <= {8'($urandom), vol};
    @(posedge clk);
    cfg_index <= CFG_SINK_LEVEL;
    cfg_data  <= {1'($urandom), sink};
    @(posedge clk);
    cfg_index <= CFG_QUIET;
    cfg_data  <= {6'($urandom), quiet};
    @(posedge clk);
    cfg_index <= CFG_PERIOD;
    cfg_data  <= period;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_sink  = int'(sink);
    cur_quiet = int'(quiet);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Segments of steady climb, sink or threshold-hugging samples, plus noise
  task automatic run_random_phase(input int n_items);
    int sent;
    int seg_len;
    int kind;
    int base;
    int jit;
    int step_max;
    int r;
    int k;
    sent = 0;
    while (sent < n_items) begin
      seg_len = $urandom_range(3, 30);
      kind    = $urandom_range(0, 9);
      jit     = $urandom_range(0, 80);
      case ($urandom_range(0, 3))
        0:       step_max = 10;
        1:       step_max = 60;
        2:       step_max = 400;
        default: step_max = 3000;
      endcase
      // jump the clock anywhere, or just short of the wrap
      if ($urandom_range(0, 24) == 0)
        t_ms = $urandom;
      else if ($urandom_range(0, 24) == 0)
        t_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      if (kind <= 4)
        base = int'($urandom_range(0, 1100));
      else if (kind <= 6)
        base = cur_sink - int'($urandom_range(1, 3000));
      else if (kind == 7)
        base = (($urandom_range(0, 1) == 0) ? cur_sink : cur_quiet) +
               int'($urandom_range(0, 40)) - 20;
      else
        base = 0;
      for (k = 0; k < seg_len && sent < n_items; k++) begin
        if (kind >= 8)
          r = int'($signed(15'($urandom)));
        else
          r = base + int'($urandom_range(0, 2 * jit)) - jit;
        if (r > 16383) r = 16383;
        if (r < -16384) r = -16384;
        t_ms = t_ms + $urandom_range(0, step_max);
        send_sample(15'(r), t_ms);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.climb_rate  = '0;
    in_chan.time_now    = '0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_VOLUME;
    cfg_data            = '0;
    hold_req            = 1'b0;
    rx_idle_pct         = 0;
    tx_idle_pct         = 0;
    cur_sink            = int'(SINK_RST);
    cur_quiet           = int'(QUIET_RST);
    t_ms                = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);

    // Directed samples with the reset register values
    send_sample(15'sd0, 32'd0);          // silent below the quiet level
    send_sample(RATE_MAX, 32'd10);       // first beep, clamped to the top tone
    send_sample(RATE_MAX, 32'd20);       // tone still on
    send_sample(RATE_MAX, 32'd510);      // beep ends and restarts on the period
    send_sample(RATE_MIN, 32'd520);
    send_sample(RATE_MIN, 32'd530);
    send_sample(RATE_MIN, 32'd540);      // sink alarm starts
    send_sample(RATE_MIN, 32'd550);      // alarm held
    send_sample(RATE_MAX, 32'd560);
    send_sample(RATE_MAX, 32'd570);
    send_sample(RATE_MAX, 32'd580);      // leave the alarm while the tone is on
    send_sample(RATE_MAX, 32'd590);
    send_sample(RATE_MAX, 32'd1100);     // retune from the alarm tone
    send_sample(15'sd10, 32'd1200);
    send_sample(15'sd10, 32'd1210);
    send_sample(15'sd10, 32'd1220);
    send_sample(15'sd10, 32'd1230);
    send_sample(15'sd10, 32'd2200);      // average at the bottom of the tone range
    send_sample(-15'sd1, 32'd2300);
    send_sample(15'sd255, 32'hFFFF_FFF0); // beep end wraps past zero
    send_sample(15'sd255, 32'hFFFF_FFF8); // wrapped compare ends the beep early
    send_sample(15'sd255, 32'd5);
    send_sample(15'sd500, 32'd600);
    send_sample(RATE_MIN, 32'd610);
    t_ms = 32'd610;
    drain_results();

    // Sender idles often, receiver stalls most of the time
    tx_idle_pct = 34;
    rx_idle_pct <= 87;
    apply_settings(8'd0, -15'sd10000, 10'd0, 16'd1);
    run_random_phase(PHASE_ITEMS);
    drain_results();
    apply_settings(8'd255, 15'sd0, 10'd1000, 16'd65535);
    run_random_phase(PHASE_ITEMS);
    drain_results();
    apply_settings(8'd128, -15'sd500, 10'd50, 16'd200);
    run_random_phase(PHASE_ITEMS);
    drain_results();

    // Swap the idle rates; zero period and the widest values here
    tx_idle_pct = 87;
    rx_idle_pct <= 34;
    apply_settings(8'($urandom), 15'($urandom), 10'($urandom), 16'd0);
    run_random_phase(PHASE_ITEMS);
    drain_results();
    apply_settings(8'd255, RATE_MIN, 10'd1023, 16'd300);
    run_random_phase(PHASE_ITEMS);
    drain_results();
    apply_settings(8'($urandom), 15'($urandom), 10'($urandom), 16'($urandom));
    run_random_phase(PHASE_ITEMS);
    drain_results();

    // No idling; hold the receiver off so the block backs up
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    apply_settings(8'd77, -15'sd1, 10'd0, 16'd100);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    run_random_phase(PHASE_ITEMS);
    drain_results();
    apply_settings(VOL_W'(VOLUME_RST), SINK_RST, QUIET_RST, PERIOD_RST);
    run_random_phase(PHASE_ITEMS);
    drain_results();

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### vario_climb_tone_scheduler.f
+incdir+hdl
hdl/vct_pkg.sv
hdl/vct_if.sv
hdl/vario_climb_tone_scheduler.sv
bench/vct_tone_checker.sv
bench/tb_vario_climb_tone_scheduler.sv
